// File: rtl/tev_pkg.sv
// shared constants for the turning envelope unit
`default_nettype none

package tev_pkg;

	localparam int LEN_BITS_DEF = 20;
	localparam int SAT_W        = 64;

endpackage

`default_nettype wire

// File: rtl/tev_if.sv
// query and reply channel interfaces of the turning envelope unit
`default_nettype none

interface tev_query_if import tev_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic        [LEN_BITS-1:0] steer_radius;
	logic        [LEN_BITS-1:0] wheelbase;
	logic        [LEN_BITS-1:0] body_width;
	logic signed [LEN_BITS:0]   front_offset;
	logic signed [LEN_BITS:0]   rear_offset;
	logic signed [LEN_BITS:0]   kingpin_offset;
	logic        [LEN_BITS-1:0] hitch_length;
	logic        [LEN_BITS-1:0] trailer_width;
	logic        [LEN_BITS-1:0] trailer_front_overhang;
	logic        [LEN_BITS-1:0] trailer_rear_overhang;

	modport source (
		output valid, steer_radius, wheelbase, body_width, front_offset, rear_offset,
		       kingpin_offset, hitch_length, trailer_width, trailer_front_overhang,
		       trailer_rear_overhang,
		input  ready
	);
	modport sink (
		input  valid, steer_radius, wheelbase, body_width, front_offset, rear_offset,
		       kingpin_offset, hitch_length, trailer_width, trailer_front_overhang,
		       trailer_rear_overhang,
		output ready
	);
endinterface

interface tev_reply_if import tev_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [LEN_BITS+2:0] inner_reach;
	logic signed [LEN_BITS+2:0] outer_reach;
	logic                       holds;

	modport source (
		output valid, inner_reach, outer_reach, holds,
		input  ready
	);
	modport sink (
		input  valid, inner_reach, outer_reach, holds,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/tev_isqrt.sv
// pipelined floor square root, two radicand bits per stage
`default_nettype none

module tev_isqrt #(
	parameter int IN_W = 51
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [IN_W-1:0]         x,
	output logic      [(IN_W+1)/2-1:0]   root
);

	localparam int N   = (IN_W + 1) / 2;
	localparam int EW  = 2 * N;
	localparam int RMW = N + 2;

	logic [EW-1:0]  x_q    [N];
	logic [RMW-1:0] rem_q  [N];
	logic [N-1:0]   root_q [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [EW-1:0]  x_in;
		logic [RMW-1:0] rem_in;
		logic [N-1:0]   root_in;
		logic [RMW-1:0] rem_sh;
		logic [RMW-1:0] trial;

		if (i == 0) begin : g_first
			assign x_in    = EW'(x);
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign x_in    = x_q[i-1];
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
		end

		assign rem_sh = {rem_in[RMW-3:0], x_in[EW-1 -: 2]};
		assign trial  = {root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[i] <= x_in << 2;
				if (rem_sh >= trial) begin
					rem_q[i]  <= rem_sh - trial;
					root_q[i] <= {root_in[N-2:0], 1'b1};
				end else begin
					rem_q[i]  <= rem_sh;
					root_q[i] <= {root_in[N-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[N-1];

endmodule

`default_nettype wire

// File: rtl/tev_delay.sv
// enable-gated delay line that keeps sideband aligned with a root pipeline
`default_nettype none

module tev_delay #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] line_q [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < D; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[D-1];

endmodule

`default_nettype wire

// File: rtl/turning_envelope_unit.sv
// top level of the turning envelope unit
// radicand width: RW = min(2 * LEN_BITS + 11, 64)
// throughput: one beat per cycle; the whole pipeline holds while a reply beat waits
// latency is set by four dependent root pipelines of two radicand bits per stage
// reset: asynchronous arst_n clears all valid bits, no reply is pending after reset
`default_nettype none

module turning_envelope_unit import tev_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tev_query_if.sink   query,
	tev_reply_if.source reply
);

	localparam int UW    = LEN_BITS + 5;
	localparam int PW    = 2 * UW;
	localparam int SQ    = PW + 1;
	localparam int RW    = (SQ > SAT_W) ? SAT_W : SQ;
	localparam int RTW   = (RW + 1) / 2;
	localparam int LQ    = (RW + 1) / 2;
	localparam int OUT_W = LEN_BITS + 3;

	typedef struct packed {
		logic          v;
		logic          rej;
		logic [UW-1:0] s2;
		logic [UW-1:0] half;
		logic [UW-1:0] fr2;
		logic [UW-1:0] rr2;
		logic [UW-1:0] kp2;
		logic [UW-1:0] h2;
		logic [UW-1:0] thalf;
		logic [UW-1:0] tf2;
		logic [UW-1:0] tr2;
	} sba_t;

	typedef struct packed {
		logic             v;
		logic             rej;
		logic [UW-1:0]    s2;
		logic signed [UW:0] inner;
		logic [UW-1:0]    h2;
		logic [UW-1:0]    thalf;
		logic [UW-1:0]    tf2;
		logic [UW-1:0]    tr2;
	} sbb_t;

	typedef struct packed {
		logic             v;
		logic             rej;
		logic [UW-1:0]    s2;
		logic signed [UW:0] inner;
		logic [UW-1:0]    outer;
		logic [UW-1:0]    h2;
		logic [UW-1:0]    thalf;
		logic [UW-1:0]    tf2;
		logic [UW-1:0]    tr2;
	} sbc_t;

	typedef struct packed {
		logic             v;
		logic             rej;
		logic             trl;
		logic [UW-1:0]    s2;
		logic signed [UW:0] inner;
		logic [UW-1:0]    outer;
		logic signed [UW:0] tin;
	} sbd_t;

	function automatic logic [RW-1:0] sat_rad(input logic [SQ-1:0] s);
		logic [SQ-1:0] hi;
		hi = s >> SAT_W;
		if (SQ > SAT_W && hi != '0) return '1;
		return RW'(s);
	endfunction

	function automatic logic [UW-1:0] smag2(input logic signed [LEN_BITS:0] v);
		logic [LEN_BITS:0] m;
		m = v[LEN_BITS] ? (LEN_BITS+1)'(0) - v : v;
		return UW'({m, 1'b0});
	endfunction

	function automatic logic [OUT_W-1:0] clamp(input logic signed [UW+1:0] h);
		if (&h[UW+1:OUT_W-1] || ~|h[UW+1:OUT_W-1]) return h[OUT_W-1:0];
		return h[UW+1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
	endfunction

	logic en;
	assign en          = !reply.valid || reply.ready;
	assign query.ready = en;

	// front: doubled lengths, squares, fixed-axle radicand
	sba_t          a_s1, a_s2, a_s3, a_d;
	logic [UW-1:0] wb2_s1;
	logic [PW-1:0] sq_s_s2, sq_w_s2;
	logic [RW-1:0] rad_f_s3;
	logic [RTW-1:0] root_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1 <= '0;
			a_s2 <= '0;
			a_s3 <= '0;
			wb2_s1 <= '0;
			sq_s_s2 <= '0;
			sq_w_s2 <= '0;
			rad_f_s3 <= '0;
		end else if (en) begin
			a_s1.v     <= query.valid;
			a_s1.rej   <= (query.steer_radius <= query.wheelbase);
			a_s1.s2    <= UW'({query.steer_radius, 1'b0});
			wb2_s1     <= UW'({query.wheelbase, 1'b0});
			a_s1.half  <= UW'(query.body_width);
			a_s1.fr2   <= smag2(query.front_offset);
			a_s1.rr2   <= smag2(query.rear_offset);
			a_s1.kp2   <= smag2(query.kingpin_offset);
			a_s1.h2    <= UW'({query.hitch_length, 1'b0});
			a_s1.thalf <= UW'(query.trailer_width);
			a_s1.tf2   <= UW'({query.trailer_front_overhang, 1'b0});
			a_s1.tr2   <= UW'({query.trailer_rear_overhang, 1'b0});

			a_s2     <= a_s1;
			sq_s_s2  <= PW'(a_s1.s2) * PW'(a_s1.s2);
			sq_w_s2  <= PW'(wb2_s1) * PW'(wb2_s1);

			a_s3     <= a_s2;
			rad_f_s3 <= RW'(sq_s_s2 - sq_w_s2);
		end
	end

	tev_isqrt #(.IN_W(RW)) u_sqrt_f (.clk(clk), .en(en), .x(rad_f_s3), .root(root_f));
	tev_delay #(.W($bits(sba_t)), .D(LQ)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en), .d(a_s3), .q(a_d)
	);

	// tractor corners and kingpin circle
	logic [UW-1:0]  fixed, wide;
	sbb_t           b_s4, b_s5, b_d;
	logic [PW-1:0]  sq_wide_s4, sq_fr_s4, sq_rr_s4, sq_f_s4, sq_kp_s4;
	logic [RW-1:0]  rad_o1_s5, rad_o2_s5, rad_k_s5;
	logic [RTW-1:0] root_o1, root_o2, root_k;

	assign fixed = UW'(root_f);
	assign wide  = fixed + a_d.half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_s4 <= '0;
			b_s5 <= '0;
			sq_wide_s4 <= '0;
			sq_fr_s4 <= '0;
			sq_rr_s4 <= '0;
			sq_f_s4 <= '0;
			sq_kp_s4 <= '0;
			rad_o1_s5 <= '0;
			rad_o2_s5 <= '0;
			rad_k_s5 <= '0;
		end else if (en) begin
			b_s4.v     <= a_d.v;
			b_s4.rej   <= a_d.rej;
			b_s4.s2    <= a_d.s2;
			b_s4.inner <= $signed({1'b0, fixed}) - $signed({1'b0, a_d.half});
			b_s4.h2    <= a_d.h2;
			b_s4.thalf <= a_d.thalf;
			b_s4.tf2   <= a_d.tf2;
			b_s4.tr2   <= a_d.tr2;
			sq_wide_s4 <= PW'(wide) * PW'(wide);
			sq_fr_s4   <= PW'(a_d.fr2) * PW'(a_d.fr2);
			sq_rr_s4   <= PW'(a_d.rr2) * PW'(a_d.rr2);
			sq_f_s4    <= PW'(fixed) * PW'(fixed);
			sq_kp_s4   <= PW'(a_d.kp2) * PW'(a_d.kp2);

			b_s5      <= b_s4;
			rad_o1_s5 <= sat_rad(SQ'(sq_wide_s4) + SQ'(sq_fr_s4));
			rad_o2_s5 <= sat_rad(SQ'(sq_wide_s4) + SQ'(sq_rr_s4));
			rad_k_s5  <= sat_rad(SQ'(sq_f_s4) + SQ'(sq_kp_s4));
		end
	end

	tev_isqrt #(.IN_W(RW)) u_sqrt_o1 (.clk(clk), .en(en), .x(rad_o1_s5), .root(root_o1));
	tev_isqrt #(.IN_W(RW)) u_sqrt_o2 (.clk(clk), .en(en), .x(rad_o2_s5), .root(root_o2));
	tev_isqrt #(.IN_W(RW)) u_sqrt_k  (.clk(clk), .en(en), .x(rad_k_s5),  .root(root_k));
	tev_delay #(.W($bits(sbb_t)), .D(LQ)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(en), .d(b_s5), .q(b_d)
	);

	// trailer axle circle
	logic [UW-1:0]  king, o1, o2;
	logic           trl_b;
	sbc_t           c_s6, c_s7, c_d;
	logic [PW-1:0]  sq_k_s6, sq_h_s6;
	logic [RW-1:0]  rad_t_s7;
	logic [RTW-1:0] root_t;

	assign king  = UW'(root_k);
	assign o1    = UW'(root_o1);
	assign o2    = UW'(root_o2);
	assign trl_b = b_d.h2 != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s6 <= '0;
			c_s7 <= '0;
			sq_k_s6 <= '0;
			sq_h_s6 <= '0;
			rad_t_s7 <= '0;
		end else if (en) begin
			c_s6.v     <= b_d.v;
			c_s6.rej   <= b_d.rej || (trl_b && king <= b_d.h2);
			c_s6.s2    <= b_d.s2;
			c_s6.inner <= b_d.inner;
			c_s6.outer <= (o1 > o2) ? o1 : o2;
			c_s6.h2    <= b_d.h2;
			c_s6.thalf <= b_d.thalf;
			c_s6.tf2   <= b_d.tf2;
			c_s6.tr2   <= b_d.tr2;
			sq_k_s6    <= PW'(king) * PW'(king);
			sq_h_s6    <= PW'(b_d.h2) * PW'(b_d.h2);

			c_s7     <= c_s6;
			rad_t_s7 <= RW'(sq_k_s6 - sq_h_s6);
		end
	end

	tev_isqrt #(.IN_W(RW)) u_sqrt_t (.clk(clk), .en(en), .x(rad_t_s7), .root(root_t));
	tev_delay #(.W($bits(sbc_t)), .D(LQ)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .en(en), .d(c_s7), .q(c_d)
	);

	// trailer corners
	logic [UW-1:0]  axle, twide, treach;
	sbd_t           d_s8, d_s9, d_d;
	logic [PW-1:0]  sq_tw_s8, sq_tf_s8, sq_tr_s8;
	logic [RW-1:0]  rad_p1_s9, rad_p2_s9;
	logic [RTW-1:0] root_p1, root_p2;

	assign axle   = UW'(root_t);
	assign twide  = axle + c_d.thalf;
	assign treach = c_d.h2 + c_d.tf2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_s8 <= '0;
			d_s9 <= '0;
			sq_tw_s8 <= '0;
			sq_tf_s8 <= '0;
			sq_tr_s8 <= '0;
			rad_p1_s9 <= '0;
			rad_p2_s9 <= '0;
		end else if (en) begin
			d_s8.v     <= c_d.v;
			d_s8.rej   <= c_d.rej;
			d_s8.trl   <= c_d.h2 != '0;
			d_s8.s2    <= c_d.s2;
			d_s8.inner <= c_d.inner;
			d_s8.outer <= c_d.outer;
			d_s8.tin   <= $signed({1'b0, axle}) - $signed({1'b0, c_d.thalf});
			sq_tw_s8   <= PW'(twide) * PW'(twide);
			sq_tf_s8   <= PW'(treach) * PW'(treach);
			sq_tr_s8   <= PW'(c_d.tr2) * PW'(c_d.tr2);

			d_s9      <= d_s8;
			rad_p1_s9 <= sat_rad(SQ'(sq_tw_s8) + SQ'(sq_tf_s8));
			rad_p2_s9 <= sat_rad(SQ'(sq_tw_s8) + SQ'(sq_tr_s8));
		end
	end

	tev_isqrt #(.IN_W(RW)) u_sqrt_p1 (.clk(clk), .en(en), .x(rad_p1_s9), .root(root_p1));
	tev_isqrt #(.IN_W(RW)) u_sqrt_p2 (.clk(clk), .en(en), .x(rad_p2_s9), .root(root_p2));
	tev_delay #(.W($bits(sbd_t)), .D(LQ)) u_dly_d (
		.clk(clk), .arst_n(arst_n), .en(en), .d(d_s9), .q(d_d)
	);

	// envelope merge, halving and clamp
	logic signed [UW:0]   in_sel;
	logic [UW-1:0]        out_sel, p1, p2, pmax;
	logic signed [UW+1:0] d_in, d_out;
	logic                 valid_s10, holds_s10;
	logic [OUT_W-1:0]     inner_s10, outer_s10;

	assign p1   = UW'(root_p1);
	assign p2   = UW'(root_p2);
	assign pmax = (p1 > p2) ? p1 : p2;

	always_comb begin
		in_sel  = d_d.inner;
		out_sel = d_d.outer;
		if (d_d.trl) begin
			if (d_d.tin < d_d.inner) in_sel = d_d.tin;
			if (pmax > d_d.outer) out_sel = pmax;
		end
		d_in  = $signed({2'b00, d_d.s2}) - $signed({in_sel[UW], in_sel});
		d_out = $signed({2'b00, out_sel}) - $signed({2'b00, d_d.s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			holds_s10 <= 1'b0;
			inner_s10 <= '0;
			outer_s10 <= '0;
		end else if (en) begin
			valid_s10 <= d_d.v;
			holds_s10 <= !d_d.rej;
			inner_s10 <= d_d.rej ? '0 : clamp(d_in >>> 1);
			outer_s10 <= d_d.rej ? '0 : clamp(d_out >>> 1);
		end
	end

	assign reply.valid       = valid_s10;
	assign reply.holds       = holds_s10;
	assign reply.inner_reach = inner_s10;
	assign reply.outer_reach = outer_s10;

	logic signed [OUT_W:0] reach_sum;
	assign reach_sum = $signed({inner_s10[OUT_W-1], inner_s10})
		+ $signed({outer_s10[OUT_W-1], outer_s10});

	a_rejected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && !reply.holds |-> reply.inner_reach == '0 && reply.outer_reach == '0)
		else $error("rejected reply carries nonzero reach");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && !reply.ready |-> !query.ready)
		else $error("pipeline takes a query while the reply stalls");

	a_envelope_order: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && reply.holds |-> reach_sum >= -1)
		else $error("outer envelope lies inside inner envelope");

endmodule

`default_nettype wire
